>>> src/bba_pkg.sv
// Package with the shared constants, codes and types of the bitmap block allocator.
`default_nettype none

package bba_pkg;

  localparam int MAX_BLOCKS = 4096;
  localparam int WORD_BITS  = 64;
  localparam int WORD_COUNT = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;

  localparam int BLK_W    = $clog2(MAX_BLOCKS);
  localparam int CNT_W    = BLK_W + 1;
  localparam int BIT_W    = $clog2(WORD_BITS);
  localparam int WADDR_W  = $clog2(WORD_COUNT);
  localparam int STATUS_W = 2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(MAX_BLOCKS);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_t;

  typedef logic [WORD_BITS-1:0] word_t;

endpackage

`default_nettype wire

>>> src/bba_req_if.sv
// Request channel: operation code and block number with a valid/ready handshake.
`default_nettype none

interface bba_req_if
  import bba_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [BLK_W-1:0] block_number;

  modport source (output valid, output func, output block_number, input ready);
  modport sink (input valid, input func, input block_number, output ready);
endinterface

`default_nettype wire

>>> src/bba_rsp_if.sv
// Response channel: granted block and status with a valid/ready handshake.
`default_nettype none

interface bba_rsp_if
  import bba_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [BLK_W-1:0]    granted_block;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output granted_block, output status, input ready);
  modport sink (input valid, input granted_block, input status, output ready);
endinterface

`default_nettype wire

>>> src/bba_bitmap_mem.sv
// Usage bitmap storage: one word per row, registered read, per-row valid bits.
`default_nettype none

module bba_bitmap_mem
  import bba_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               we,
  input  wire logic [WADDR_W-1:0] waddr,
  input  wire word_t              wdata,
  input  wire logic [WADDR_W-1:0] raddr,
  output word_t                   rdata
);

  word_t                 mem [WORD_COUNT];
  logic [WORD_COUNT-1:0] row_valid;
  word_t                 rd_q;
  logic                  rd_valid_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // A row never written since reset reads as all free.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we) begin
        row_valid[waddr] <= 1'b1;
      end
      rd_valid_q <= row_valid[raddr];
    end
  end

  assign rdata = rd_valid_q ? rd_q : '0;

endmodule

`default_nettype wire

>>> src/bitmap_block_allocator.sv
// Bitmap block allocator: top level with the scan sequencer and response register.
//
// Requests arrive on the req channel (func 0 allocates, func 1 frees block_number)
// and each produces exactly one transaction on the rsp channel carrying
// granted_block and status. total_blocks is written through cfg_we/cfg_wdata;
// the user must write it only while the block is idle, which the block does
// not enforce. Values above the capacity act as the capacity. The block works
// on one request at a time: req.ready is high only when the sequencer is idle.
// An allocate reads the bitmap one 64-bit word per cycle and runs a single
// priority encoder on each word, from word 0 up to the first word with a free
// block below the count (at most 64 words). A free reads one word; a free out
// of range and an allocate with a count of zero go straight to the response.
// The sequencer returns to idle only once the response loads, and only then
// does it accept the next request.
// The response sits in an output register; a stalled receiver holds it there
// while the next request is still accepted and processed, and that request
// waits only for the register to empty before its response loads.
// Reset is synchronous: it marks every block free (per-row valid bits, no
// clearing pass), sets total_blocks to 4096 and drops any pending response.
`default_nettype none

module bitmap_block_allocator
  import bba_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  bba_req_if.sink               req,
  bba_rsp_if.source             rsp,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FREE_CHK,
    S_RESP
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    total_blocks;
  logic [CNT_W-1:0]    cnt_q;
  logic [BLK_W-1:0]    blk_q;
  logic [WADDR_W-1:0]  chk_ptr;
  logic [BLK_W-1:0]    res_granted;
  status_t             res_status;
  logic                out_valid;
  logic [BLK_W-1:0]    out_granted;
  logic [STATUS_W-1:0] out_status;

  logic [CNT_W-1:0]    cnt_eff;
  logic [CNT_W-1:0]    rem;
  word_t               limit_mask;
  word_t               avail;
  logic                found;
  logic [BIT_W-1:0]    find_bit;
  logic                last_word;
  logic                free_bit;
  logic                mem_we;
  logic [WADDR_W-1:0]  mem_waddr;
  word_t               mem_wdata;
  logic [WADDR_W-1:0]  mem_raddr;
  word_t               mem_rdata;
  logic                req_fire;
  logic                out_load;

  bba_bitmap_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign cnt_eff  = (total_blocks > TOTAL_RESET) ? TOTAL_RESET : total_blocks;
  assign req_fire = req.valid && req.ready;
  assign out_load = (state == S_RESP) && (!out_valid || rsp.ready);

  // Shared scan unit: masks blocks at or beyond the count, then finds the
  // lowest free bit of the word that arrived from the bitmap.
  always_comb begin
    rem        = cnt_q - {{(CNT_W - WADDR_W - BIT_W){1'b0}}, chk_ptr, {BIT_W{1'b0}}};
    last_word  = (rem <= CNT_W'(WORD_BITS));
    limit_mask = (rem >= CNT_W'(WORD_BITS)) ? '0 : ('1 << rem[BIT_W-1:0]);
    avail      = ~(mem_rdata | limit_mask);
    found      = 1'b0;
    find_bit   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        found    = 1'b1;
        find_bit = BIT_W'(i);
      end
    end
    free_bit = mem_rdata[blk_q[BIT_W-1:0]];
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = blk_q[BLK_W-1:BIT_W];
    mem_wdata = mem_rdata & ~(word_t'(1) << blk_q[BIT_W-1:0]);
    mem_raddr = chk_ptr + WADDR_W'(1);
    unique case (state)
      S_IDLE: begin
        mem_raddr = (req.func == FUNC_FREE) ? req.block_number[BLK_W-1:BIT_W] : '0;
      end
      S_SCAN: begin
        mem_we    = found;
        mem_waddr = chk_ptr;
        mem_wdata = mem_rdata | (word_t'(1) << find_bit);
      end
      S_FREE_CHK: begin
        mem_we = free_bit;
      end
      S_RESP: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      total_blocks <= TOTAL_RESET;
      out_valid    <= 1'b0;
      chk_ptr      <= '0;
    end else begin
      if (cfg_we) begin
        total_blocks <= cfg_wdata;
      end
      if (out_load) begin
        out_valid   <= 1'b1;
        out_granted <= res_granted;
        out_status  <= res_status;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            cnt_q       <= cnt_eff;
            blk_q       <= req.block_number;
            chk_ptr     <= '0;
            res_granted <= '0;
            if (req.func == FUNC_ALLOC) begin
              if (cnt_eff == '0) begin
                res_status <= ST_NO_FREE;
                state      <= S_RESP;
              end else begin
                state <= S_SCAN;
              end
            end else if ({1'b0, req.block_number} >= cnt_eff) begin
              res_status <= ST_OUT_OF_RANGE;
              state      <= S_RESP;
            end else begin
              state <= S_FREE_CHK;
            end
          end
        end
        S_SCAN: begin
          if (found) begin
            res_granted <= {chk_ptr, find_bit};
            res_status  <= ST_OK;
            state       <= S_RESP;
          end else if (last_word) begin
            res_status <= ST_NO_FREE;
            state      <= S_RESP;
          end else begin
            chk_ptr <= chk_ptr + WADDR_W'(1);
          end
        end
        S_FREE_CHK: begin
          res_status <= free_bit ? ST_OK : ST_ALREADY_FREE;
          state      <= S_RESP;
        end
        S_RESP: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.granted_block = out_granted;
  assign rsp.status        = out_status;

`ifndef SYNTH
  // The bitmap is only written while checking a scanned word or a freed block.
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_SCAN || state == S_FREE_CHK))
    else $error("bitmap written outside scan or free check");

  // A granted block always lies below the block count in effect.
  a_grant_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && found) |-> ({1'b0, chk_ptr, find_bit} < cnt_q))
    else $error("granted block at or beyond the block count");

  // Only a successful transaction carries a nonzero block number.
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> (rsp.granted_block == '0))
    else $error("nonzero granted block on a failed request");

  // One request at a time: an accepted request drops ready in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> !req.ready)
    else $error("request accepted while another is in progress");
`endif

endmodule

`default_nettype wire
